### hdl/i2cw_pkg.sv
// Package with the phase codes, field widths and constants of the I2C bit-bang writer.
package i2cw_pkg;

    localparam int unsigned PHASE_W = 4;
    localparam int unsigned WAIT_W  = 17;
    localparam int unsigned DELAY_W = 16;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_SDA = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_SCL = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_HIGH  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_LOW   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_ACK_A     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ACK_B     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STOP_SDA  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_STOP_SCL  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_STOP_REL  = 4'd10;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd50;
    localparam logic [DELAY_W-1:0] DELAY_MIN   = 16'd2;
    localparam logic [3:0]         BITS_PER_BYTE = 4'd8;

endpackage

### hdl/i2c_master_bit_bang_writer.sv
// Write-only I2C master that produces one SCL/SDA sample for every input tick.
//
// Usage: every transfer on the slave stream is one tick of the bit clock. tuser carries
// the command (none, start plus address, write byte, stop), tdata the address or byte
// and the sampled SDA level. Each tick yields exactly one transfer on the master stream
// with the driven SCL and SDA levels, the busy flag and the acknowledge result.
// Commands given while a sequence is running are dropped; a start sends the 7-bit
// address with the write bit, a write sends one byte, a stop ends the frame.
// The user must write the half-bit delay register through i_cfg_we/i_cfg_wdata only
// while idle; the block does not enforce this. Values below two behave as two.
// A tick accepted into the input register is evaluated once the result register is free
// or being taken, and its result is registered there. Throughput is one tick per clock
// cycle while the receiver does not stall; the only loop is the phase/counter update.
// Reset puts both lines in the released state, the phase in idle and the delay at 50.
// When the receiver stalls, the result register holds its transfer and the input
// register holds one more tick, then o_s_axis_tready drops until the stall clears.
module i2c_master_bit_bang_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] data, [8] sda_in, [15:9] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // [0] scl_out, [1] sda_out, [2] busy_res,
                                         // [3] ack_valid, [4] acked, [7:5] zero
);

    localparam int unsigned PW = i2cw_pkg::PHASE_W;
    localparam int unsigned WW = i2cw_pkg::WAIT_W;
    localparam int unsigned DW = i2cw_pkg::DELAY_W;

    // Configuration register.
    logic [DW-1:0] r_half_bit;

    // Input register holding one accepted tick.
    logic          r_in_valid;
    logic [1:0]    r_in_cmd;
    logic [7:0]    r_in_data;
    logic          r_in_sda;

    // Bus sequencer state.
    logic [PW-1:0] r_phase,     n_phase;
    logic [3:0]    r_bit_count, n_bit_count;
    logic [7:0]    r_shift,     n_shift;
    logic [WW-1:0] r_wait,      n_wait;
    logic          r_scl,       n_scl;
    logic          r_sda,       n_sda;

    // Result register.
    logic          r_out_valid;
    logic [4:0]    r_out_data,  n_out_data;

    logic          step;        // the held tick is evaluated this cycle
    logic [DW-1:0] delay;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_data};
    assign delay = (r_half_bit < i2cw_pkg::DELAY_MIN) ? i2cw_pkg::DELAY_MIN : r_half_bit;

    // One tick of the sequencer: optional command entry, line levels, then the
    // countdown and any phase change it triggers.
    always_comb begin
        logic busy;
        logic ack_valid;
        logic acked;
        logic scl_drv;
        logic sda_drv;
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_scl       = r_scl;
        n_sda       = r_sda;
        busy        = 1'b0;
        ack_valid   = 1'b0;
        acked       = 1'b0;

        if (r_phase == i2cw_pkg::PH_IDLE) begin
            case (r_in_cmd)
                i2cw_pkg::CMD_START: begin
                    n_phase = i2cw_pkg::PH_START_SDA;
                    n_sda   = 1'b0;
                    n_wait  = {1'b0, delay};
                    n_shift = {r_in_data[6:0], 1'b0};
                end
                i2cw_pkg::CMD_WRITE: begin
                    n_bit_count = 4'd0;
                    n_phase     = i2cw_pkg::PH_BIT_HIGH;
                    n_scl       = 1'b1;
                    n_sda       = r_in_data[7];
                    n_shift     = {r_in_data[6:0], 1'b0};
                    n_wait      = {1'b0, delay};
                end
                i2cw_pkg::CMD_STOP: begin
                    n_phase = i2cw_pkg::PH_STOP_SDA;
                    n_sda   = 1'b0;
                    n_wait  = {1'b0, delay};
                end
                default: begin
                end
            endcase
        end

        scl_drv = n_scl;
        sda_drv = n_sda;

        if (n_phase != i2cw_pkg::PH_IDLE) begin
            busy = 1'b1;
            if (n_wait != '0) begin
                n_wait = n_wait - WW'(1);
            end
            if (n_wait == '0) begin
                case (n_phase)
                    i2cw_pkg::PH_START_SDA: begin
                        n_phase = i2cw_pkg::PH_START_SCL;
                        n_scl   = 1'b0;
                        n_wait  = {1'b0, delay};
                    end
                    i2cw_pkg::PH_START_SCL: begin
                        // Address byte is already in the shift register.
                        n_bit_count = 4'd0;
                        n_phase     = i2cw_pkg::PH_BIT_HIGH;
                        n_scl       = 1'b1;
                        n_sda       = n_shift[7];
                        n_shift     = {n_shift[6:0], 1'b0};
                        n_wait      = {1'b0, delay};
                    end
                    i2cw_pkg::PH_BIT_HIGH: begin
                        n_phase = i2cw_pkg::PH_BIT_LOW;
                        n_scl   = 1'b0;
                        n_wait  = {1'b0, delay};
                    end
                    i2cw_pkg::PH_BIT_LOW: begin
                        n_bit_count = n_bit_count + 4'd1;
                        if (n_bit_count >= i2cw_pkg::BITS_PER_BYTE) begin
                            n_phase = i2cw_pkg::PH_ACK_A;
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_wait  = {2'b00, delay[DW-1:1]};
                        end else begin
                            n_phase = i2cw_pkg::PH_BIT_HIGH;
                            n_scl   = 1'b1;
                            n_sda   = n_shift[7];
                            n_shift = {n_shift[6:0], 1'b0};
                            n_wait  = {1'b0, delay};
                        end
                    end
                    i2cw_pkg::PH_ACK_A: begin
                        // Midpoint of the ninth clock: sample the acknowledge.
                        ack_valid = 1'b1;
                        acked     = !r_in_sda;
                        n_phase   = i2cw_pkg::PH_ACK_B;
                        n_scl     = 1'b1;
                        n_sda     = 1'b1;
                        n_wait    = {1'b0, delay - {1'b0, delay[DW-1:1]}};
                    end
                    i2cw_pkg::PH_ACK_B: begin
                        n_phase = i2cw_pkg::PH_ACK_LOW;
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                        n_wait  = {1'b0, delay};
                    end
                    i2cw_pkg::PH_STOP_SDA: begin
                        n_phase = i2cw_pkg::PH_STOP_SCL;
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_wait  = {1'b0, delay};
                    end
                    i2cw_pkg::PH_STOP_SCL: begin
                        n_phase = i2cw_pkg::PH_STOP_REL;
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_wait  = {delay, 1'b0};
                    end
                    i2cw_pkg::PH_ACK_LOW, i2cw_pkg::PH_STOP_REL: begin
                        n_phase = i2cw_pkg::PH_IDLE;
                    end
                    default: begin
                        n_phase = i2cw_pkg::PH_IDLE;
                        n_wait  = '0;
                    end
                endcase
            end
        end

        n_out_data = {acked, ack_valid, busy, sda_drv, scl_drv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit  <= i2cw_pkg::DELAY_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= i2cw_pkg::PH_IDLE;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_wait      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_half_bit <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_wait      <= n_wait;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata[7:0];
            r_in_sda  <= i_s_axis_tdata[8];
        end
        if (step) begin
            r_out_data <= n_out_data;
        end
    end

    // An idle sequencer never has a countdown in flight.
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cw_pkg::PH_IDLE) |-> (r_wait == '0))
        else $error("countdown left running in idle");

    // The bit counter never passes the byte length.
    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= i2cw_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");

    // An acknowledge result is only reported while busy with SDA released.
    a_ack_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[3]) |-> (r_out_data[2] && r_out_data[1] && r_out_data[0]))
        else $error("acknowledge reported outside a released ninth clock");

    // The acked flag never appears without a valid acknowledge.
    a_acked_qualified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[4]) |-> r_out_data[3])
        else $error("acked set without ack_valid");

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

endmodule

### tb/sv/tb_i2c_master_bit_bang_writer.sv
// Self-checking testbench for the write-only I2C master with per-tick line prediction.
module tb_i2c_master_bit_bang_writer;
    timeunit 1ns;
    timeprecision 1ps;

    // A stall of the result side that the stimulus requests once, long enough for the
    // block to fill its registers and drop o_s_axis_tready.
    localparam int unsigned HOLD_CYCLES    = 64;
    // Cycles without any transfer on either side before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Cycles to let pass after the last result before a register write or the verdict.
    localparam int unsigned SETTLE_CYCLES  = 4;

    // One tick of the bit clock as it goes into the block.
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       sda_in;
    } t_bus_tick;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [15:0] i_cfg_wdata     = 16'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = 16'd0;  // [7:0] data, [8] sda_in, [15:9] zero
    logic [1:0]  i_s_axis_tuser  = i2cw_pkg::CMD_NONE; // [1:0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;  // [0] scl_out, [1] sda_out, [2] busy_res,
                                  // [3] ack_valid, [4] acked, [7:5] zero

    i2c_master_bit_bang_writer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Ticks waiting to be offered, and the line samples predicted for accepted ticks.
    t_bus_tick  tick_queue[$];
    logic [7:0] line_samples[$];

    int unsigned pushed_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned error_count  = 0;

    // Percent of cycles in which each side stays idle, changed between phases.
    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 87;

    // Bumping the token asks the receiver for one long hold-off, sized by HOLD_CYCLES.
    int unsigned hold_token = 0;

    // Effective half-bit length that the stimulus uses to lay out command sequences.
    int unsigned cur_delay = 50;

    string field_names[5] = '{"scl_out", "sda_out", "busy_res", "ack_valid", "acked"};

    // ------------------------------------------------------------------------
    // Line-level predictor: its own copy of the delay register and the sequencer.
    // ------------------------------------------------------------------------
    logic [15:0] half_bit_copy = i2cw_pkg::DELAY_RESET;
    logic [3:0]  seq_phase     = i2cw_pkg::PH_IDLE;
    logic [3:0]  bits_sent     = 4'd0;
    logic [7:0]  out_byte      = 8'd0;
    logic [16:0] ticks_left    = 17'd0;
    logic        scl_level     = 1'b1;
    logic        sda_level     = 1'b1;

    task automatic enter_phase(input logic [3:0] ph, input logic scl, input logic sda,
                               input logic [16:0] len);
        seq_phase  = ph;
        scl_level  = scl;
        sda_level  = sda;
        ticks_left = len;
    endtask

    // The next bit goes out MSB first and SCL rises with it.
    task automatic shift_next_bit(input logic [16:0] d);
        logic b;
        b        = out_byte[7];
        out_byte = {out_byte[6:0], 1'b0};
        enter_phase(i2cw_pkg::PH_BIT_HIGH, 1'b1, b, d);
    endtask

    task automatic predict_line_sample(input t_bus_tick t, output logic [7:0] sample);
        logic [16:0] d;
        logic        scl_now, sda_now, busy, ack_seen, ack_low;
        d = {1'b0, half_bit_copy};
        if (half_bit_copy < i2cw_pkg::DELAY_MIN)
            d = {1'b0, i2cw_pkg::DELAY_MIN};
        busy     = 1'b0;
        ack_seen = 1'b0;
        ack_low  = 1'b0;

        // A command is only taken while idle; a start or stop keeps SCL at whatever level it had, a write raises it.
        if (seq_phase == i2cw_pkg::PH_IDLE) begin
            case (t.cmd)
                i2cw_pkg::CMD_START: begin
                    enter_phase(i2cw_pkg::PH_START_SDA, scl_level, 1'b0, d);
                    out_byte = {t.data[6:0], 1'b0};
                end
                i2cw_pkg::CMD_WRITE: begin
                    out_byte  = t.data;
                    bits_sent = 4'd0;
                    shift_next_bit(d);
                end
                i2cw_pkg::CMD_STOP: enter_phase(i2cw_pkg::PH_STOP_SDA, scl_level, 1'b0, d);
                default: ;
            endcase
        end

        scl_now = scl_level;
        sda_now = sda_level;

        if (seq_phase != i2cw_pkg::PH_IDLE) begin
            busy = 1'b1;
            if (ticks_left != 17'd0)
                ticks_left = ticks_left - 17'd1;
            if (ticks_left == 17'd0) begin
                if (seq_phase == i2cw_pkg::PH_ACK_A) begin
                    ack_seen = 1'b1;
                    ack_low  = ~t.sda_in;
                end
                case (seq_phase)
                    i2cw_pkg::PH_ACK_LOW, i2cw_pkg::PH_STOP_REL:
                        seq_phase = i2cw_pkg::PH_IDLE;
                    i2cw_pkg::PH_START_SDA:
                        enter_phase(i2cw_pkg::PH_START_SCL, 1'b0, sda_level, d);
                    i2cw_pkg::PH_START_SCL: begin
                        bits_sent = 4'd0;
                        shift_next_bit(d);
                    end
                    i2cw_pkg::PH_BIT_HIGH:
                        enter_phase(i2cw_pkg::PH_BIT_LOW, 1'b0, sda_level, d);
                    i2cw_pkg::PH_BIT_LOW: begin
                        bits_sent = bits_sent + 4'd1;
                        if (bits_sent >= i2cw_pkg::BITS_PER_BYTE)
                            enter_phase(i2cw_pkg::PH_ACK_A, 1'b1, 1'b1, d >> 1);
                        else
                            shift_next_bit(d);
                    end
                    i2cw_pkg::PH_ACK_A:
                        enter_phase(i2cw_pkg::PH_ACK_B, 1'b1, 1'b1, d - (d >> 1));
                    i2cw_pkg::PH_ACK_B:
                        enter_phase(i2cw_pkg::PH_ACK_LOW, 1'b0, 1'b1, d);
                    i2cw_pkg::PH_STOP_SDA:
                        enter_phase(i2cw_pkg::PH_STOP_SCL, 1'b1, 1'b0, d);
                    i2cw_pkg::PH_STOP_SCL:
                        enter_phase(i2cw_pkg::PH_STOP_REL, 1'b1, 1'b1, d << 1);
                    default: begin
                        seq_phase  = i2cw_pkg::PH_IDLE;
                        ticks_left = 17'd0;
                    end
                endcase
            end
        end

        sample = {3'b000, ack_low, ack_seen, busy, sda_now, scl_now};
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued ticks, predicts each one as its transfer completes.
    // ------------------------------------------------------------------------
    t_bus_tick cur_tick;

    always @(posedge i_clk) begin
        logic [7:0] sample;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 16'd0;
            i_s_axis_tuser  <= i2cw_pkg::CMD_NONE;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_line_sample(cur_tick, sample);
                line_samples.push_back(sample);
                accepted_cnt++;
            end
            // A new tick is presented only once the previous one has been taken, so
            // tvalid gets at most one assignment per edge.
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_tick = tick_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {7'd0, cur_tick.sda_in, cur_tick.data};
                    i_s_axis_tuser  <= cur_tick.cmd;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off when requested.
    // ------------------------------------------------------------------------
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen       <= hold_token;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every result transfer is checked field by field against the oldest
    // predicted sample.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (line_samples.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $realtime, o_m_axis_tdata);
                error_count++;
            end else begin
                want = line_samples.pop_front();
                for (int k = 0; k < 5; k++) begin
                    if (o_m_axis_tdata[k] !== want[k]) begin
                        $display("%0t: %s mismatch, expected %b, actual %b", $realtime,
                                 field_names[k], want[k], o_m_axis_tdata[k]);
                        error_count++;
                    end
                end
                if (o_m_axis_tdata[7:5] !== 3'b000) begin
                    $display("%0t: padding mismatch, expected 000, actual %b", $realtime,
                             o_m_axis_tdata[7:5]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run in which nothing moves for too long has hung.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("i2c_master_bit_bang_writer regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_tick(input logic [1:0] cmd, input logic [7:0] data, input logic sda);
        t_bus_tick t;
        t.cmd    = cmd;
        t.data   = data;
        t.sda_in = sda;
        tick_queue.push_back(t);
        pushed_cnt++;
    endtask

    // Ticks with no command; after a completed sequence the block is idle, so they only pass time.
    task automatic idle_ticks(input int unsigned n);
        repeat (n) push_tick(i2cw_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
    endtask

    // One command followed by exactly as many ticks as its sequence lasts, so that the
    // tick after the last one finds the block idle. A start spans 20 half-bits, a byte
    // 18 and a stop 4. noise_pct of the busy ticks carry a command that must be ignored.
    task automatic run_command(input logic [1:0] cmd, input logic [7:0] data,
                               input int unsigned noise_pct);
        int unsigned len;
        case (cmd)
            i2cw_pkg::CMD_START: len = 20 * cur_delay;
            i2cw_pkg::CMD_WRITE: len = 18 * cur_delay;
            default:             len = 4 * cur_delay;
        endcase
        push_tick(cmd, data, 1'($urandom));
        for (int unsigned k = 1; k < len; k++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_tick(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
            else
                push_tick(i2cw_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
        end
    endtask

    // Waits until every queued tick has gone in and every predicted sample has come
    // out, then lets the pipeline settle.
    task automatic drain;
        while (accepted_cnt != pushed_cnt || line_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The delay register is only written with the block drained and idle.
    task automatic set_delay(input logic [15:0] value);
        drain();
        @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= value;
        half_bit_copy =  value;
        cur_delay     =  (value < i2cw_pkg::DELAY_MIN) ? 32'(i2cw_pkg::DELAY_MIN) : 32'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly complete frames (start, zero to three bytes, stop) with random content; the rest
    // are broken sequences such as a lone byte or a lone stop.
    task automatic random_frames(input int unsigned target_ticks);
        int unsigned first, pick;
        first = pushed_cnt;
        while (pushed_cnt - first < target_ticks) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                run_command(i2cw_pkg::CMD_START, 8'($urandom), 5);
                idle_ticks($urandom_range(0, 2));
                repeat ($urandom_range(0, 3)) begin
                    run_command(i2cw_pkg::CMD_WRITE, 8'($urandom), 5);
                    idle_ticks($urandom_range(0, 2));
                end
                run_command(i2cw_pkg::CMD_STOP, 8'($urandom), 5);
            end else if (pick == 7) begin
                run_command(i2cw_pkg::CMD_WRITE, 8'($urandom), 10);
            end else if (pick == 8) begin
                run_command(i2cw_pkg::CMD_STOP, 8'($urandom), 10);
            end else begin
                run_command(i2cw_pkg::CMD_START, 8'($urandom), 10);
                run_command(i2cw_pkg::CMD_STOP, 8'($urandom), 10);
            end
            idle_ticks($urandom_range(0, 3));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A stop at the reset delay checks the delay that reset leaves behind.
        send_idle_pct = 25;
        recv_idle_pct = 87;
        idle_ticks(3);
        run_command(i2cw_pkg::CMD_STOP, 8'h00, 0);

        // Directed frame: the address byte with bit 7 set (it must be dropped),
        // all-zero and all-ones data, commands while busy, a stop with SCL low after
        // a byte and a second stop with SCL already high.
        set_delay(16'd4);
        run_command(i2cw_pkg::CMD_START, 8'hFF, 0);
        run_command(i2cw_pkg::CMD_WRITE, 8'h00, 0);
        run_command(i2cw_pkg::CMD_WRITE, 8'hFF, 30);
        run_command(i2cw_pkg::CMD_STOP, 8'h00, 0);
        run_command(i2cw_pkg::CMD_STOP, 8'h5A, 0);
        idle_ticks(5);

        // Delays of zero and one behave as two.
        set_delay(16'd0);
        run_command(i2cw_pkg::CMD_START, 8'h00, 0);
        run_command(i2cw_pkg::CMD_WRITE, 8'hA5, 20);
        run_command(i2cw_pkg::CMD_STOP, 8'h00, 0);
        run_command(i2cw_pkg::CMD_WRITE, 8'h3C, 0);
        set_delay(16'd1);
        run_command(i2cw_pkg::CMD_START, 8'h2A, 0);
        run_command(i2cw_pkg::CMD_STOP, 8'h81, 0);
        idle_ticks(2);

        // Random frames, first with a slow receiver.
        set_delay(16'd2);
        random_frames(250);

        // Then with a slow sender and an odd delay, so the acknowledge halves differ.
        set_delay(16'd3);
        send_idle_pct = 87;
        recv_idle_pct = 25;
        random_frames(250);

        // No idling; the receiver holds off long enough for the input to back up.
        set_delay(16'($urandom_range(4, 5)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge i_clk);
        hold_token <= hold_token + 1;
        random_frames(250);

        // The largest delay loads the countdown with its largest half-bit value; the stop is left running.
        set_delay(16'hFFFF);
        push_tick(i2cw_pkg::CMD_STOP, 8'($urandom), 1'($urandom));
        idle_ticks(40);

        drain();
        if (error_count == 0)
            $display("i2c_master_bit_bang_writer regression: pass");
        else
            $display("i2c_master_bit_bang_writer regression: fail");
        $finish;
    end

endmodule
